@@ hw/rtl/vnsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package vnsc_pkg;

  // message store geometry
  localparam int MSG_DEPTH = 64;
  localparam int ADDR_W    = $clog2(MSG_DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int KEY_MAX   = 8;
  localparam int KPOS_W    = $clog2(KEY_MAX);

  // character constants
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_DIFF  = 8'd32;
  localparam logic [5:0] ALPHA_LEN  = 6'd26;

  // configuration register indexes
  localparam logic REG_KEY_LETTERS = 1'b0;
  localparam logic REG_KEY_LENGTH  = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_KEY  = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  // message mode
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_START,
    ST_FWD,
    ST_REV
  } vnsc_state_t;

  // key unit status toward the sequencer
  typedef struct packed {
    logic                  key_ok;
    logic [4:0]            key_off;
    logic [KPOS_W-1:0]     len_m1;
  } vnsc_key_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    to_upper = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_DIFF : c;
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    is_upper = (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  function automatic logic [3:0] swap_pairs(input logic [3:0] h);
    swap_pairs = {h[2], h[3], h[0], h[1]};
  endfunction

  function automatic logic [7:0] scramble(input logic [7:0] b);
    logic [3:0] h;
    h = swap_pairs(b[7:4]);
    scramble = {h, b[3:0] ^ h};
  endfunction

  function automatic logic [7:0] unscramble(input logic [7:0] b);
    unscramble = {swap_pairs(b[7:4]), b[3:0] ^ b[7:4]};
  endfunction

  // reduce 0..51 into 0..25
  function automatic logic [4:0] mod_alpha(input logic [5:0] v);
    logic [5:0] r;
    r = (v >= ALPHA_LEN) ? v - ALPHA_LEN : v;
    mod_alpha = r[4:0];
  endfunction

  // letter offset of an upper-case letter
  function automatic logic [4:0] letter_off(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_UPPER_A;
    letter_off = d[4:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/vnsc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vnsc_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [vnsc_pkg::ADDR_W-1:0] waddr,
  input  wire logic [7:0]                wdata,
  input  wire logic                      re,
  input  wire logic [vnsc_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                     rdata
);
  import vnsc_pkg::*;

  logic [7:0] mem [MSG_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/vnsc_key.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vnsc_key (
  input  wire logic [63:0]                 key_letters,
  input  wire logic [3:0]                  key_length,
  input  wire logic [vnsc_pkg::KPOS_W-1:0] key_pos,
  output vnsc_pkg::vnsc_key_t              key_st
);
  import vnsc_pkg::*;

  logic [3:0]        len_c;
  logic [KPOS_W-1:0] len_m1;
  logic [KEY_MAX-1:0] bad;
  logic [7:0]        cur_ch;

  // clamp length into 1..KEY_MAX
  always_comb begin
    if (key_length == 4'd0) begin
      len_c = 4'd1;
    end else if (key_length > 4'(KEY_MAX)) begin
      len_c = 4'(KEY_MAX);
    end else begin
      len_c = key_length;
    end
    len_m1 = KPOS_W'(len_c - 4'd1);
  end

  // every used key character must be a letter
  always_comb begin
    for (int i = 0; i < KEY_MAX; i++) begin
      bad[i] = (KPOS_W'(i) <= len_m1) && !is_upper(to_upper(key_letters[i*8 +: 8]));
    end
  end

  // current key character
  assign cur_ch = to_upper(key_letters[{key_pos, 3'b000} +: 8]);

  assign key_st.key_ok  = (bad == '0);
  assign key_st.key_off = letter_off(cur_ch);
  assign key_st.len_m1  = len_m1;

endmodule
`default_nettype wire

@@ hw/rtl/reverse_vigenere_nibble_scramble_cipher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// loading takes one byte per cycle into a 64-entry store, input ready only while loading
// encrypt: key check state, then store reads in reverse order into the output register
// decrypt: key check state, store rewrite in message order, then reversed store reads;
// a bad key gives a single error result from the key check state
// emission rate is one result per cycle while the receiver takes results, set by the single store read port
// reset (rst_n low, synchronous) empties the store and clears key position and mode
module reverse_vigenere_nibble_scramble_cipher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,
  input  wire logic        in_tuser,   // [0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,
  output logic [1:0]       out_tuser   // [1:0] status
);
  import vnsc_pkg::*;

  // configuration registers
  logic [63:0] key_letters_r;
  logic [3:0]  key_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_letters_r <= '0;
      key_length_r  <= 4'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_KEY_LETTERS: key_letters_r <= cfg_wdata;
        REG_KEY_LENGTH:  key_length_r  <= cfg_wdata[3:0];
        default:         key_length_r  <= key_length_r;
      endcase
    end
  end

  vnsc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic              ovf_r, ovf_nxt;
  logic              mode_r, mode_nxt;
  logic [KPOS_W-1:0] kpos_r, kpos_nxt;
  logic              out_v_r, out_v_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic [1:0]        out_stat_r, out_stat_nxt;

  vnsc_key_t         key_st;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  vnsc_key u_key (
    .key_letters (key_letters_r),
    .key_length  (key_length_r),
    .key_pos     (kpos_r),
    .key_st      (key_st)
  );

  vnsc_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic             in_acc, out_free, rd_more, issue;
  logic [CNT_W-1:0] rev_addr;
  logic [7:0]       enc_up, dec_un, enc_res, dec_res;
  logic             enc_let, dec_let;
  logic [KPOS_W-1:0] kpos_adv;
  logic [1:0]       run_stat;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_v_r || out_tready;
  assign rd_more   = (iss_r < cnt_r);
  assign rev_addr  = cnt_r - CNT_W'(1) - iss_r;
  assign kpos_adv  = (kpos_r == key_st.len_m1) ? '0 : kpos_r + KPOS_W'(1);
  assign run_stat  = ovf_r ? STAT_OVERFLOW : STAT_OK;

  // encrypt path: upper-case, shift letters forward, scramble nibbles
  assign enc_up  = to_upper(ram_rdata);
  assign enc_let = is_upper(enc_up);
  assign enc_res = scramble(enc_let ?
                   CH_UPPER_A + 8'(mod_alpha({1'b0, letter_off(enc_up)} +
                                             {1'b0, key_st.key_off})) : enc_up);

  // decrypt path: undo nibbles, shift upper-case letters back
  assign dec_un  = unscramble(ram_rdata);
  assign dec_let = is_upper(dec_un);
  assign dec_res = dec_let ?
                   CH_UPPER_A + 8'(mod_alpha({1'b0, letter_off(dec_un)} + ALPHA_LEN -
                                             {1'b0, key_st.key_off})) : dec_un;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    iss_nxt      = iss_r;
    rd_idx_nxt   = rd_idx_r;
    rd_v_nxt     = rd_v_r;
    ovf_nxt      = ovf_r;
    mode_nxt     = mode_r;
    kpos_nxt     = kpos_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_stat_nxt = out_stat_r;
    ram_we       = 1'b0;
    ram_waddr    = cnt_r[ADDR_W-1:0];
    ram_wdata    = in_tdata;
    ram_re       = 1'b0;
    ram_raddr    = iss_r[ADDR_W-1:0];
    issue        = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r == '0) begin
            mode_nxt = in_tuser;
          end
          if (cnt_r < CNT_W'(MSG_DEPTH)) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_START;
          end
        end
      end

      ST_START: begin
        iss_nxt  = '0;
        rd_v_nxt = 1'b0;
        kpos_nxt = '0;
        if (!key_st.key_ok) begin
          // one error result, message discarded
          if (out_free) begin
            out_v_nxt    = 1'b1;
            out_byte_nxt = '0;
            out_last_nxt = 1'b1;
            out_stat_nxt = STAT_BAD_KEY;
            cnt_nxt      = '0;
            ovf_nxt      = 1'b0;
            state_nxt    = ST_LOAD;
          end
        end else if (mode_r == MODE_DEC) begin
          state_nxt = ST_FWD;
        end else begin
          state_nxt = ST_REV;
        end
      end

      ST_FWD: begin
        // read-modify-write in message order
        issue = rd_more;
        if (rd_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r;
          ram_wdata = dec_res;
          if (dec_let) begin
            kpos_nxt = kpos_adv;
          end
          rd_v_nxt = 1'b0;
          if ({1'b0, rd_idx_r} == cnt_r - CNT_W'(1)) begin
            state_nxt = ST_REV;
            kpos_nxt  = '0;
          end
        end
        if (issue) begin
          ram_re     = 1'b1;
          ram_raddr  = iss_r[ADDR_W-1:0];
          rd_idx_nxt = iss_r[ADDR_W-1:0];
          rd_v_nxt   = 1'b1;
          iss_nxt    = iss_r + CNT_W'(1);
        end
        if (state_nxt == ST_REV) begin
          iss_nxt = '0;
        end
      end

      ST_REV: begin
        // reversed emission, one read in flight at most
        if (rd_v_r && out_free) begin
          out_v_nxt    = 1'b1;
          out_stat_nxt = run_stat;
          out_last_nxt = (rd_idx_r == '0);
          rd_v_nxt     = 1'b0;
          if (mode_r == MODE_DEC) begin
            out_byte_nxt = to_upper(ram_rdata);
          end else begin
            out_byte_nxt = enc_res;
            if (enc_let) begin
              kpos_nxt = kpos_adv;
            end
          end
          issue = rd_more;
          if (rd_idx_r == '0) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            kpos_nxt  = '0;
          end
        end else if (!rd_v_r) begin
          issue = rd_more;
        end
        if (issue) begin
          ram_re     = 1'b1;
          ram_raddr  = rev_addr[ADDR_W-1:0];
          rd_idx_nxt = rev_addr[ADDR_W-1:0];
          rd_v_nxt   = 1'b1;
          iss_nxt    = iss_r + CNT_W'(1);
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      iss_r   <= '0;
      rd_v_r  <= 1'b0;
      ovf_r   <= 1'b0;
      mode_r  <= MODE_ENC;
      kpos_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      iss_r   <= iss_nxt;
      rd_v_r  <= rd_v_nxt;
      ovf_r   <= ovf_nxt;
      mode_r  <= mode_nxt;
      kpos_r  <= kpos_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stat_r;

endmodule
`default_nettype wire

@@ tb/reverse_vigenere_nibble_scramble_cipher_tb.sv @@
`timescale 1ns / 1ps
module reverse_vigenere_nibble_scramble_cipher_tb;
  import vnsc_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TOTAL_ITEMS   = 220;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } cipher_result_t;

  // predicts the reversed cipher output and checks it in order
  class cipher_scoreboard;
    logic [7:0]     msg_bytes [MSG_DEPTH];
    int             msg_count;
    logic           msg_mode;
    bit             msg_ovf;
    logic [63:0]    key_bytes;
    logic [3:0]     key_len_reg;
    cipher_result_t pending_q [$];
    int             err_count;

    function new();
      msg_count   = 0;
      msg_mode    = MODE_ENC;
      msg_ovf     = 0;
      key_bytes   = '0;
      key_len_reg = 4'd1;
      err_count   = 0;
    endfunction

    task report(input string msg);
      if (err_count < 50) $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
    endtask

    function void set_reg(input logic idx, input logic [63:0] val);
      if (idx == REG_KEY_LETTERS) begin
        key_bytes = val;
      end else begin
        key_len_reg = val[3:0];
      end
    endfunction

    function logic [7:0] upcase(input logic [7:0] c);
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return c - CASE_DIFF;
      return c;
    endfunction

    function bit is_cap(input logic [7:0] c);
      return c >= CH_UPPER_A && c <= CH_UPPER_Z;
    endfunction

    function logic [3:0] pair_swap(input logic [3:0] h);
      return ((h << 1) & 4'hA) | ((h >> 1) & 4'h5);
    endfunction

    function logic [7:0] mix_byte(input logic [7:0] b);
      logic [3:0] hi;
      hi = pair_swap(b[7:4]);
      return {hi, hi ^ b[3:0]};
    endfunction

    function logic [7:0] unmix_byte(input logic [7:0] b);
      return {pair_swap(b[7:4]), b[7:4] ^ b[3:0]};
    endfunction

    function logic [7:0] key_at(input int i);
      return upcase(key_bytes[8*i +: 8]);
    endfunction

    // vigenere shift of an upper-case letter, forward or back
    function logic [7:0] shift_letter(input logic [7:0] c, input logic [7:0] k, input bit back);
      int cv;
      int kv;
      cv = c - CH_UPPER_A;
      kv = k - CH_UPPER_A;
      if (back) cv = (cv + int'(ALPHA_LEN) - kv) % int'(ALPHA_LEN);
      else cv = (cv + kv) % int'(ALPHA_LEN);
      return CH_UPPER_A + 8'(cv);
    endfunction

    // store one accepted request; on the last byte queue the whole run
    function void note_request(input logic cmd, input logic [7:0] b, input logic last);
      logic [7:0]     plain [MSG_DEPTH];
      logic [7:0]     c;
      logic [1:0]     st;
      int             len;
      int             kpos;
      int             n;
      bit             bad;
      cipher_result_t r;
      if (msg_count == 0) msg_mode = cmd;
      if (msg_count < MSG_DEPTH) begin
        msg_bytes[msg_count] = b;
        msg_count++;
      end else begin
        msg_ovf = 1;
      end
      if (!last) return;

      len = (key_len_reg == 0) ? 1 : (key_len_reg > KEY_MAX) ? KEY_MAX : int'(key_len_reg);
      bad = 0;
      for (int i = 0; i < len; i++) begin
        if (!is_cap(key_at(i))) bad = 1;
      end

      if (bad) begin
        // invalid key character: single error result, message dropped
        r.data   = 8'd0;
        r.last   = 1'b1;
        r.status = STAT_BAD_KEY;
        pending_q.push_back(r);
      end else begin
        n    = msg_count;
        st   = msg_ovf ? STAT_OVERFLOW : STAT_OK;
        kpos = 0;
        for (int i = 0; i < n; i++) begin
          if (msg_mode == MODE_ENC) c = upcase(msg_bytes[n-1-i]);
          else c = unmix_byte(msg_bytes[i]);
          if (is_cap(c)) begin
            c    = shift_letter(c, key_at(kpos), msg_mode == MODE_DEC);
            kpos = (kpos + 1 >= len) ? 0 : kpos + 1;
          end
          plain[i] = (msg_mode == MODE_ENC) ? mix_byte(c) : c;
        end
        for (int i = 0; i < n; i++) begin
          r.data   = (msg_mode == MODE_ENC) ? plain[i] : upcase(plain[n-1-i]);
          r.last   = (i == n - 1);
          r.status = st;
          pending_q.push_back(r);
        end
      end
      msg_count = 0;
      msg_ovf   = 0;
    endfunction

    // compare one accepted result against the oldest prediction
    task check_result(input logic [7:0] data, input logic last,
                      input logic [1:0] status);
      cipher_result_t exp_r;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result byte %h last %b status %0d", data, last, status));
        return;
      end
      exp_r = pending_q.pop_front();
      if (data !== exp_r.data)
        report($sformatf("out_byte %h, predicted %h", data, exp_r.data));
      if (last !== exp_r.last)
        report($sformatf("out_last %b, predicted %b", last, exp_r.last));
      if (status !== exp_r.status)
        report($sformatf("status %0d, predicted %0d", status, exp_r.status));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_addr;
  logic [63:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;
  logic        in_tuser;   // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic        out_tlast;
  logic [1:0]  out_tuser;  // [1:0] status

  logic [5:0]  rx_tick = '0;
  logic [1:0]  rx_mode = '0;

  cipher_scoreboard sb;
  logic [7:0]       msg_q [$];
  int               burst_left;
  int               items_sent;
  int               cycle_count;

  reverse_vigenere_nibble_scramble_cipher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stall pattern, reshuffled each time the 6-bit tick counter wraps
  always @(posedge clk) begin
    rx_tick <= rx_tick + 6'd1;
    if (rx_tick == 6'd0) rx_mode <= 2'($urandom_range(0, 2));
    case (rx_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= rx_tick[3];
    endcase
  end

  // accepted requests feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata, in_tlast);
  end

  // accepted results are checked
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  // overall run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("reverse_vigenere_nibble_scramble_cipher regression: fail");
    $finish;
  end

  function automatic logic [63:0] key_of(input string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) k[8*i +: 8] = s[i];
    return k;
  endfunction

  // one request, with burst gaps in front of it
  task automatic send_item(input logic cmd, input logic [7:0] b, input logic last);
    int   gap;
    logic took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= cmd;
    in_tlast  <= last;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  // send msg_q as one message; command only matters on the first byte
  task automatic send_msg(input logic cmd);
    for (int i = 0; i < msg_q.size(); i++)
      send_item((i == 0) ? cmd : 1'($urandom_range(0, 1)), msg_q[i], i == msg_q.size() - 1);
  endtask

  // wait until every predicted result has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_key(input logic [63:0] letters, input logic [3:0] len);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_KEY_LETTERS;
    cfg_wdata <= letters;
    @(posedge clk);
    sb.set_reg(REG_KEY_LETTERS, letters);
    cfg_addr  <= REG_KEY_LENGTH;
    cfg_wdata <= {60'd0, len};
    @(posedge clk);
    sb.set_reg(REG_KEY_LENGTH, {60'd0, len});
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // mostly letters; decrypt input mostly scrambled letters
  task automatic fill_random(input logic cmd, input int len);
    int         r;
    logic [7:0] letter;
    msg_q.delete();
    for (int i = 0; i < len; i++) begin
      r      = $urandom_range(0, 9);
      letter = CH_UPPER_A + 8'($urandom_range(0, 25));
      if (r < 4) msg_q.push_back(letter);
      else if (r < 7) msg_q.push_back(letter + CASE_DIFF);
      else msg_q.push_back(8'($urandom_range(1, 255)));
      if (cmd == MODE_DEC && r < 7) msg_q[i] = sb.mix_byte(msg_q[i]);
    end
  endtask

  // random key of mixed case, sometimes with a bad character or odd length
  task automatic random_key();
    logic [63:0] k;
    logic [3:0]  len;
    logic [7:0]  c;
    int          p;
    for (int i = 0; i < 8; i++)
      k[8*i +: 8] = CH_UPPER_A + 8'($urandom_range(0, 25)) +
                    ($urandom_range(0, 1) ? CASE_DIFF : 8'd0);
    p   = $urandom_range(0, 9);
    len = 4'($urandom_range(1, 8));
    if (p == 0) len = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
    if (p == 1) begin
      do c = 8'($urandom_range(0, 255)); while (sb.is_cap(sb.upcase(c)));
      k[8*$urandom_range(0, 7) +: 8] = c;
    end
    if (p == 2) k = {$urandom, $urandom};
    write_key(k, len);
  endtask

  initial begin
    int   r;
    int   len;
    logic cmd;
    sb         = new();
    burst_left = 0;
    items_sent = 0;
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_addr   = REG_KEY_LETTERS;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    in_tuser   = MODE_ENC;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key is a zero byte: error result
    msg_q = '{8'h41};
    send_msg(MODE_ENC);
    drain_results();

    // letter edges, zero byte and neighbors of the letter ranges
    write_key(key_of("KEY"), 4'd3);
    msg_q = '{8'h61, 8'h5A, 8'h7A, 8'h41, 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B};
    send_msg(MODE_ENC);
    msg_q = '{sb.mix_byte(8'h41), sb.mix_byte(8'h5A), 8'h01, 8'h80, sb.mix_byte(8'h6D)};
    send_msg(MODE_DEC);
    msg_q = '{sb.mix_byte(8'h51), 8'h62};
    send_msg(MODE_DEC);
    drain_results();

    // key length zero taken as one
    write_key(key_of("Q"), 4'd0);
    msg_q = '{8'h41, 8'h42};
    send_msg(MODE_ENC);
    drain_results();

    // key length above eight, full message store on decrypt
    write_key(key_of("abcdefgh"), 4'd15);
    fill_random(MODE_DEC, MSG_DEPTH);
    send_msg(MODE_DEC);
    drain_results();

    // bad character outside the used key length is ignored
    write_key(key_of("Z1"), 4'd1);
    msg_q = '{8'h79, 8'h21};
    send_msg(MODE_ENC);
    drain_results();

    // bad character inside the used key length
    write_key(key_of("A@"), 4'd2);
    msg_q = '{sb.mix_byte(8'h43), 8'h78};
    send_msg(MODE_DEC);
    drain_results();
    write_key({64{1'b1}}, 4'd8);
    msg_q = '{8'h6B};
    send_msg(MODE_ENC);
    drain_results();

    // message longer than the store
    write_key(key_of("ZZZZZZZZ"), 4'd8);
    fill_random(MODE_ENC, MSG_DEPTH + 2);
    send_msg(MODE_ENC);
    drain_results();

    // random messages, mostly short, with key changes and full drains
    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        drain_results();
        random_key();
      end else if (r < 22) begin
        drain_results();
      end
      cmd = 1'($urandom_range(0, 1));
      r   = $urandom_range(0, 99);
      if (r < 3) len = $urandom_range(MSG_DEPTH - 2, MSG_DEPTH + 4);
      else if (r < 18) len = 1;
      else len = $urandom_range(2, 12);
      fill_random(cmd, len);
      send_msg(cmd);
    end

    drain_results();
    if (sb.pending_q.size() != 0) sb.report("predicted results never arrived");
    if (sb.err_count == 0) begin
      $display("reverse_vigenere_nibble_scramble_cipher regression: pass");
    end else begin
      $display("reverse_vigenere_nibble_scramble_cipher regression: fail");
    end
    $finish;
  end

endmodule
